[design/alom_pkg.sv]
// Package with the types, codes and constants of the ADC level and overload meter.
`timescale 1ns / 1ps
`default_nettype none

package alom_pkg;

    localparam int SUM_W  = 31;
    localparam int CNT_W  = 17;
    localparam int PPM_W  = 20;
    localparam int GAP_W  = 16;
    localparam int PHASE_W = 8;
    localparam int STRIDE_W = 9;
    localparam int PROD_W = CNT_W + PPM_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 72;

    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [GAP_W-1:0]    MS_MAX     = '1;
    localparam logic [7:0]          MID_CODE   = 8'd128;
    localparam logic [PPM_W-1:0]    PPM_SCALE  = 20'd1000000;
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = 9'd256;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_STRIDE    = 3'd0,
        REG_CLIP_LOW_LIMIT   = 3'd1,
        REG_CLIP_HIGH_LIMIT  = 3'd2,
        REG_CLIP_PPM_TRIGGER = 3'd3,
        REG_OVERLOAD_GAP_MS  = 3'd4,
        REG_EVENT_ENABLE     = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_RESULT = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] clip;
    } token_t;

endpackage

`default_nettype wire

[design/adc_level_and_overload_meter.sv]
// Top level of the ADC level and overload meter.
//
// Input requests arrive on the s_axis channel: tuser carries the kind (sample byte,
// millisecond tick or overload clear), tdata the ADC byte and tlast the last byte
// of a buffer. Every stride-th byte of a buffer, starting with the first, is
// measured. On the last byte of a buffer one result leaves on the m_axis channel
// with the saturated sum of squares, the sample and clip counts, the overload
// level and the rate-limited overload event.
// A new request is taken in every cycle while the input is not stalled. A result
// passes the input register, the accumulator stage and the product stage, whose 17
// by 20 bit multipliers set the depth, and then the output register.
// Ticks and clears travel the same stages so that their order with results holds.
// Reset clears all accumulators and the overload flag, loads the registers with
// their defaults and sets the millisecond counter to its maximum, so that the
// first event is allowed. While the receiver stalls with a result waiting, sample
// bytes keep accumulating and ticks and clears still complete. Once a second result
// waits in the last stage, the next tick, clear or buffer end stops behind it, and
// the input stalls when one more request has entered the input register.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
`timescale 1ns / 1ps
`default_nettype none

module adc_level_and_overload_meter
    import alom_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] sample_byte
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] kind
    input  wire logic                  s_axis_tlast,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [30:0] sum_squares, [47:31] sample_count, [64:48] clipped_count,
    // [65] overload_level, [66] overload_event, [71:67] zero
    output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STRIDE_W-1:0] stride_reg;
    logic [7:0]          clip_low_reg;
    logic [7:0]          clip_high_reg;
    logic [PPM_W-1:0]    trigger_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic                evt_en_reg;

    logic                v1_reg;
    kind_t               kind1_reg;
    logic [7:0]          byte1_reg;
    logic                last1_reg;

    logic [PHASE_W-1:0]  phase_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    clip_reg;

    logic                v2_reg;
    token_t              tok2_reg;
    logic                v3_reg;
    token_t              tok3_reg;
    logic [PROD_W-1:0]   prod_clip_reg;
    logic [PROD_W-1:0]   prod_trig_reg;

    logic                flag_reg;
    logic [GAP_W-1:0]    ms_reg;
    logic                out_v_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                rdy2;
    logic                rdy3;
    logic                move1;
    logic                adv3;

    logic [STRIDE_W-1:0] stride_eff;
    logic                take;
    logic [7:0]          mag;
    logic [15:0]         square;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W-1:0]    clip_next;
    logic                clip_hit;
    logic [STRIDE_W-1:0] phase_plus;
    logic [PHASE_W-1:0]  phase_next;
    logic                emit2;
    token_t              tok2_next;

    logic                level;
    logic                event_fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg    <= 9'd1;
            clip_low_reg  <= 8'd0;
            clip_high_reg <= 8'd255;
            trigger_reg   <= 20'd1000;
            gap_reg       <= 16'd1000;
            evt_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_STRIDE:    stride_reg    <= cfg_data[STRIDE_W-1:0];
                REG_CLIP_LOW_LIMIT:   clip_low_reg  <= cfg_data[7:0];
                REG_CLIP_HIGH_LIMIT:  clip_high_reg <= cfg_data[7:0];
                REG_CLIP_PPM_TRIGGER: trigger_reg   <= cfg_data[PPM_W-1:0];
                REG_OVERLOAD_GAP_MS:  gap_reg       <= cfg_data[GAP_W-1:0];
                REG_EVENT_ENABLE:     evt_en_reg    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Handshake chain through the stages.
    assign adv3  = v3_reg && ((tok3_reg.op != OP_RESULT) || !out_v_reg || m_axis_tready);
    assign rdy3  = !v3_reg || adv3;
    assign rdy2  = !v2_reg || rdy3;
    assign move1 = v1_reg && rdy2;
    assign s_axis_tready = !v1_reg || rdy2;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind1_reg <= kind_t'(s_axis_tuser);
            byte1_reg <= s_axis_tdata;
            last1_reg <= s_axis_tlast;
        end
    end

    // Accumulator stage.
    always_comb
    begin
        if (stride_reg == '0)
        begin
            stride_eff = 9'd1;
        end
        else if (stride_reg > STRIDE_MAX)
        begin
            stride_eff = STRIDE_MAX;
        end
        else
        begin
            stride_eff = stride_reg;
        end

        take     = (phase_reg == '0);
        mag      = (byte1_reg >= MID_CODE) ? (byte1_reg - MID_CODE) : (MID_CODE - byte1_reg);
        square   = 16'(mag) * 16'(mag);
        sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(square);
        sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        clip_hit = (byte1_reg <= clip_low_reg) || (byte1_reg >= clip_high_reg);
        clip_next = (clip_hit && (clip_reg != CNT_MAX)) ? clip_reg + 1'b1 : clip_reg;
        if (!take)
        begin
            sum_next  = sum_reg;
            cnt_next  = cnt_reg;
            clip_next = clip_reg;
        end
        phase_plus = STRIDE_W'(phase_reg) + 1'b1;
        phase_next = (phase_plus >= stride_eff) ? '0 : phase_plus[PHASE_W-1:0];

        emit2          = 1'b0;
        tok2_next.op   = OP_RESULT;
        tok2_next.sum  = sum_next;
        tok2_next.cnt  = cnt_next;
        tok2_next.clip = clip_next;
        case (kind1_reg)
            KIND_SAMPLE:
            begin
                emit2 = last1_reg;
            end
            KIND_TICK:
            begin
                emit2        = 1'b1;
                tok2_next.op = OP_TICK;
            end
            KIND_CLEAR:
            begin
                emit2        = 1'b1;
                tok2_next.op = OP_CLEAR;
            end
            default:
            begin
                emit2 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            clip_reg  <= '0;
        end
        else if (move1 && (kind1_reg == KIND_SAMPLE))
        begin
            if (last1_reg)
            begin
                phase_reg <= '0;
                sum_reg   <= '0;
                cnt_reg   <= '0;
                clip_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                cnt_reg   <= cnt_next;
                clip_reg  <= clip_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= move1 && emit2;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && move1 && emit2)
        begin
            tok2_reg <= tok2_next;
        end
        if (rdy3 && v2_reg)
        begin
            tok3_reg      <= tok2_reg;
            prod_clip_reg <= PROD_W'(tok2_reg.clip) * PROD_W'(PPM_SCALE);
            prod_trig_reg <= PROD_W'(trigger_reg) * PROD_W'(tok2_reg.cnt);
        end
    end

    // Overload decision and output register.
    assign level      = (prod_clip_reg >= prod_trig_reg);
    assign event_fire = level && !flag_reg && evt_en_reg && (ms_reg >= gap_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            ms_reg    <= MS_MAX;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                case (tok3_reg.op)
                    OP_TICK:
                    begin
                        if (ms_reg != MS_MAX)
                        begin
                            ms_reg <= ms_reg + 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        flag_reg <= 1'b0;
                    end
                    OP_RESULT:
                    begin
                        flag_reg <= level;
                        if (event_fire)
                        begin
                            ms_reg <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (adv3 && (tok3_reg.op == OP_RESULT))
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && (tok3_reg.op == OP_RESULT))
        begin
            out_data_reg <= {5'd0, event_fire, level, tok3_reg.clip, tok3_reg.cnt, tok3_reg.sum};
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

    // An event is only reported together with a raised overload level.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[66] || m_axis_tdata[65]))
        else $error("overload event without overload level");

    // The clip count never runs ahead of the sample count.
    assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg <= cnt_reg)
        else $error("clip count exceeds sample count");

    // A fired event restarts the millisecond counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv3 && (tok3_reg.op == OP_RESULT) && event_fire) |=> (ms_reg == '0))
        else $error("event did not restart the millisecond counter");

    // An empty input register always takes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
